>>> rtl/rets_pkg.sv
// Shared types, character codes and character-class helpers for the escape token scanner.
`timescale 1ns / 1ps

package rets_pkg;

  localparam int unsigned ChW = 21;

  // Scan phases
  typedef enum logic [3:0] {
    M_IDLE      = 4'd0,
    M_ESC0      = 4'd1,
    M_ESCD      = 4'd2,
    M_GRP_FIRST = 4'd3,
    M_GRP_BODY  = 4'd4,
    M_GRP_U     = 4'd5,
    M_GRP_HEX   = 4'd6,
    M_CNT_FIRST = 4'd7,
    M_CNT_INT   = 4'd8,
    M_CNT_FRAC  = 4'd9,
    M_CP_FIRST  = 4'd10,
    M_CP_ZEROS  = 4'd11,
    M_CP_AFTER1 = 4'd12,
    M_CP_DIG    = 4'd13
  } mode_e;

  // Status codes
  localparam logic [1:0] ST_PEND   = 2'd0;
  localparam logic [1:0] ST_ACCEPT = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_IDLE   = 2'd3;

  // Token kinds
  localparam logic [1:0] KIND_NULL  = 2'd0;
  localparam logic [1:0] KIND_GROUP = 2'd1;
  localparam logic [1:0] KIND_COUNT = 2'd2;
  localparam logic [1:0] KIND_CP    = 2'd3;

  // Enable bits
  localparam int unsigned EN_NULL  = 0;
  localparam int unsigned EN_GROUP = 1;
  localparam int unsigned EN_COUNT = 2;
  localparam int unsigned EN_CP    = 3;

  // Digit limits of a code point and of a group's u escape
  localparam logic [2:0] CP_LIMIT_LONG  = 3'd5;
  localparam logic [2:0] CP_LIMIT_SHORT = 3'd4;
  localparam logic [2:0] U_ESC_DIGITS   = 3'd4;

  localparam logic [ChW-1:0] CH_EOI    = 21'h00;
  localparam logic [ChW-1:0] CH_BSLASH = 21'h5C;
  localparam logic [ChW-1:0] CH_ZERO   = 21'h30;
  localparam logic [ChW-1:0] CH_ONE    = 21'h31;
  localparam logic [ChW-1:0] CH_NINE   = 21'h39;
  localparam logic [ChW-1:0] CH_LT     = 21'h3C;
  localparam logic [ChW-1:0] CH_GT     = 21'h3E;
  localparam logic [ChW-1:0] CH_LBRACE = 21'h7B;
  localparam logic [ChW-1:0] CH_RBRACE = 21'h7D;
  localparam logic [ChW-1:0] CH_COMMA  = 21'h2C;
  localparam logic [ChW-1:0] CH_LC_U   = 21'h75;
  localparam logic [ChW-1:0] CH_LC_A   = 21'h61;
  localparam logic [ChW-1:0] CH_LC_F   = 21'h66;
  localparam logic [ChW-1:0] CH_LC_Z   = 21'h7A;
  localparam logic [ChW-1:0] CH_UC_A   = 21'h41;
  localparam logic [ChW-1:0] CH_UC_F   = 21'h46;
  localparam logic [ChW-1:0] CH_UC_Z   = 21'h5A;
  localparam logic [ChW-1:0] CH_DOLLAR = 21'h24;
  localparam logic [ChW-1:0] CH_UNDER  = 21'h5F;

  typedef struct packed {
    mode_e      mode;
    logic [2:0] dc;
    logic       sl;
    logic [3:0] en;
  } scan_state_t;

  function automatic logic is_dec(input logic [ChW-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [ChW-1:0] c);
    return is_dec(c) || ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
           ((c >= CH_UC_A) && (c <= CH_UC_F));
  endfunction

  function automatic logic is_word(input logic [ChW-1:0] c);
    return is_dec(c) || ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
           ((c >= CH_UC_A) && (c <= CH_UC_Z)) || (c == CH_DOLLAR) || (c == CH_UNDER);
  endfunction

endpackage

>>> rtl/rets_step.sv
// Next-state and result logic for one character of the escape token scanner.
`timescale 1ns / 1ps

module rets_step (
  input  logic                     start_i,
  input  logic [rets_pkg::ChW-1:0] ch_i,
  input  logic [3:0]               mask_i,
  input  rets_pkg::scan_state_t    cur_i,
  output rets_pkg::scan_state_t    nxt_o,
  output logic [1:0]               status_o,
  output logic [1:0]               kind_o
);
  import rets_pkg::*;

  always_comb begin
    mode_e      mode_v;
    logic [2:0] dc_v;
    logic       sl_v;
    logic       done;
    logic       cnt_fail;
    logic [2:0] limit;

    mode_v   = cur_i.mode;
    dc_v     = cur_i.dc;
    sl_v     = cur_i.sl;
    done     = 1'b0;
    cnt_fail = 1'b0;
    limit    = CP_LIMIT_LONG;
    status_o = ST_IDLE;
    kind_o   = KIND_NULL;
    nxt_o    = cur_i;

    if (start_i) begin
      nxt_o.en = mask_i;
      nxt_o.dc = '0;
      nxt_o.sl = 1'b0;
      if (ch_i == CH_BSLASH && mask_i[EN_NULL]) begin
        nxt_o.mode = M_ESC0;
      end else if (ch_i == CH_LT && mask_i[EN_GROUP]) begin
        nxt_o.mode = M_GRP_FIRST;
      end else if (ch_i == CH_LBRACE && mask_i[EN_COUNT]) begin
        nxt_o.mode = M_CNT_FIRST;
      end else if (ch_i == CH_LBRACE && mask_i[EN_CP]) begin
        nxt_o.mode = M_CP_FIRST;
      end else begin
        nxt_o.mode = M_IDLE;
      end
      status_o = (nxt_o.mode == M_IDLE) ? ST_REJECT : ST_PEND;
    end else if (cur_i.mode == M_IDLE) begin
      status_o = ST_IDLE;
    end else begin
      // At most four phases chain on one character: count fail, first, zeros, digits.
      for (int i = 0; i < 4; i++) begin
        if (!done) begin
          done     = 1'b1;
          cnt_fail = 1'b0;
          limit    = sl_v ? CP_LIMIT_SHORT : CP_LIMIT_LONG;
          unique case (mode_v)
            M_ESC0: begin
              if (ch_i == CH_ZERO) begin
                mode_v = M_ESCD; status_o = ST_PEND;
              end else begin
                mode_v = M_IDLE; status_o = ST_REJECT;
              end
            end
            M_ESCD: begin
              mode_v = M_IDLE;
              if (is_dec(ch_i)) begin
                status_o = ST_REJECT;
              end else begin
                status_o = ST_ACCEPT; kind_o = KIND_NULL;
              end
            end
            M_GRP_FIRST: begin
              if (ch_i == CH_GT) begin
                mode_v = M_IDLE; status_o = ST_REJECT;
              end else begin
                mode_v = M_GRP_BODY; done = 1'b0;
              end
            end
            M_GRP_BODY: begin
              if (ch_i == CH_EOI) begin
                mode_v = M_IDLE; status_o = ST_REJECT;
              end else if (ch_i == CH_GT) begin
                mode_v = M_IDLE; status_o = ST_ACCEPT; kind_o = KIND_GROUP;
              end else if (is_word(ch_i)) begin
                status_o = ST_PEND;
              end else if (ch_i == CH_BSLASH) begin
                mode_v = M_GRP_U; status_o = ST_PEND;
              end else begin
                mode_v = M_IDLE; status_o = ST_REJECT;
              end
            end
            M_GRP_U: begin
              if (ch_i != CH_LC_U) begin
                mode_v = M_IDLE; status_o = ST_REJECT;
              end else begin
                dc_v = '0; mode_v = M_GRP_HEX; status_o = ST_PEND;
              end
            end
            M_GRP_HEX: begin
              if (!is_hex(ch_i)) begin
                mode_v = M_IDLE; status_o = ST_REJECT;
              end else begin
                dc_v = dc_v + 3'd1;
                if (dc_v >= U_ESC_DIGITS) begin
                  dc_v = '0; mode_v = M_GRP_BODY;
                end
                status_o = ST_PEND;
              end
            end
            M_CNT_FIRST: begin
              if (is_dec(ch_i)) begin
                mode_v = M_CNT_INT; status_o = ST_PEND;
              end else begin
                cnt_fail = 1'b1;
              end
            end
            M_CNT_INT: begin
              if (is_dec(ch_i)) begin
                status_o = ST_PEND;
              end else if (ch_i == CH_COMMA) begin
                mode_v = M_CNT_FRAC; status_o = ST_PEND;
              end else if (ch_i == CH_RBRACE) begin
                mode_v = M_IDLE; status_o = ST_ACCEPT; kind_o = KIND_COUNT;
              end else begin
                cnt_fail = 1'b1;
              end
            end
            M_CNT_FRAC: begin
              if (is_dec(ch_i)) begin
                status_o = ST_PEND;
              end else if (ch_i == CH_RBRACE) begin
                mode_v = M_IDLE; status_o = ST_ACCEPT; kind_o = KIND_COUNT;
              end else begin
                cnt_fail = 1'b1;
              end
            end
            M_CP_FIRST: begin
              if (!is_hex(ch_i)) begin
                mode_v = M_IDLE; status_o = ST_REJECT;
              end else begin
                mode_v = M_CP_ZEROS; done = 1'b0;
              end
            end
            M_CP_ZEROS: begin
              if (ch_i == CH_ZERO) begin
                status_o = ST_PEND;
              end else begin
                dc_v = '0;
                if (ch_i == CH_ONE) begin
                  sl_v = 1'b1; mode_v = M_CP_AFTER1; status_o = ST_PEND;
                end else begin
                  sl_v = 1'b0; mode_v = M_CP_DIG; done = 1'b0;
                end
              end
            end
            M_CP_AFTER1: begin
              mode_v = M_CP_DIG;
              if (ch_i == CH_ZERO) begin
                status_o = ST_PEND;
              end else begin
                done = 1'b0;
              end
            end
            M_CP_DIG: begin
              if (dc_v >= limit) begin
                mode_v = M_IDLE;
                if (ch_i == CH_RBRACE) begin
                  status_o = ST_ACCEPT; kind_o = KIND_CP;
                end else begin
                  status_o = ST_REJECT;
                end
              end else if (ch_i == CH_EOI) begin
                mode_v = M_IDLE; status_o = ST_REJECT;
              end else if (ch_i == CH_RBRACE) begin
                mode_v = M_IDLE;
                if (dc_v != 3'd0) begin
                  status_o = ST_ACCEPT; kind_o = KIND_CP;
                end else begin
                  status_o = ST_REJECT;
                end
              end else if (!is_hex(ch_i)) begin
                mode_v = M_IDLE; status_o = ST_REJECT;
              end else begin
                dc_v = dc_v + 3'd1; status_o = ST_PEND;
              end
            end
            default: begin
              mode_v = M_IDLE; status_o = ST_IDLE;
            end
          endcase
          // Fall into the code point check at the same character, no rewind
          if (cnt_fail) begin
            if (!cur_i.en[EN_CP]) begin
              mode_v = M_IDLE; status_o = ST_REJECT;
            end else begin
              mode_v = M_CP_FIRST; done = 1'b0;
            end
          end
        end
      end
      nxt_o.mode = mode_v;
      nxt_o.dc   = dc_v;
      nxt_o.sl   = sl_v;
    end
  end

endmodule

>>> rtl/regex_escape_token_scanner.sv
// Top level of the regex escape token scanner: input register, step logic, result register.
// Path: the input register holds the character, the step logic decides on it, and the result
//   register takes the decision when the output is free or being drained.
// Throughput: one character per cycle unless the output stalls; input and result registers
//   run as a two-stage pipeline, and scan state updates as the input register drains.
// Reset: rst_ni asynchronous active low; clears both valid flags and returns the scan
//   to idle with zero digit count, limit flag and enables.
`timescale 1ns / 1ps

module regex_escape_token_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [20:0] ch, [24:21] valid_mask, rest zero
  input  logic [0:0]  s_axis_tuser,   // [0] start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [1:0] status, rest zero
  output logic [1:0]  m_axis_tuser    // [1:0] token_kind
);
  import rets_pkg::*;

  logic             in_valid_q;
  logic             start_q;
  logic [ChW-1:0]   ch_q;
  logic [3:0]       mask_q;
  logic             out_valid_q;
  logic [1:0]       status_q, status_d;
  logic [1:0]       kind_q, kind_d;
  scan_state_t      state_q, state_d;
  logic             advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  rets_step u_step (
    .start_i  (start_q),
    .ch_i     (ch_q),
    .mask_i   (mask_q),
    .cur_i    (state_q),
    .nxt_o    (state_d),
    .status_o (status_d),
    .kind_o   (kind_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{mode: M_IDLE, dc: '0, sl: 1'b0, en: '0};
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      start_q <= s_axis_tuser[0];
      ch_q    <= s_axis_tdata[ChW-1:0];
      mask_q  <= s_axis_tdata[ChW+3:ChW];
    end
    if (advance) begin
      status_q <= status_d;
      kind_q   <= kind_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, status_q};
  assign m_axis_tuser  = kind_q;

  // Kind is only reported with an accept
  a_kind_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_NULL) |-> (m_axis_tdata[1:0] == ST_ACCEPT))
    else $error("token kind set without accept");

  // A non-start character while idle yields idle status
  a_idle_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !start_q && state_q.mode == M_IDLE) |=>
      (status_q == ST_IDLE && state_q.mode == M_IDLE))
    else $error("idle scan produced non-idle result");

  // Digit counter never passes the long code point limit
  a_dc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.dc <= CP_LIMIT_LONG)
    else $error("digit count out of range");

  // Accept or reject always returns the scan to idle
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !start_q && (status_d == ST_ACCEPT || status_d == ST_REJECT)) |=>
      (state_q.mode == M_IDLE))
    else $error("scan not idle after decision");

endmodule
